// File: design/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decoder package
// Shared types, constants and helper functions for the decoder front end,
// job queue and result back end.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Job queue depth and pointer width
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Sextet count codes
    localparam logic [1:0] CNT_ZERO  = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    // Special characters
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_SLASH = 8'h2f;

    // Sextet value that marks a character outside the alphabet
    localparam logic [6:0] SEXTET_NONE = 7'd64;

    // One decoded job: the bytes that one input transaction produces
    typedef struct packed {
        logic [23:0] word;    // bytes left-aligned, first byte in [23:16]
        logic [1:0]  nres;    // number of results, 1..3
        logic        bvalid;  // 0 for the data-less end result
        logic        done;    // job closes the message
    } job_t;

    // Map a character to its sextet, or SEXTET_NONE
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        v = SEXTET_NONE;
        if (c >= 8'h41 && c <= 8'h5a) begin
            v = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            v = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 7'(c - 8'h30 + 8'd52);
        end else if (c == CHAR_PLUS) begin
            v = 7'd62;
        end else if (c == CHAR_SLASH) begin
            v = 7'd63;
        end
        return v;
    endfunction

    // Left-align a partial group so its bytes sit in [23:16] and [15:8]
    function automatic logic [23:0] align_partial(input logic [17:0] g,
                                                  input logic [1:0]  n);
        logic [23:0] w;
        w = '0;
        unique case (n)
            CNT_TWO:   w = {g[11:0], 12'b0};
            CNT_THREE: w = {g, 6'b0};
            default:   w = '0;
        endcase
        return w;
    endfunction

    // Bytes a partial group yields when flushed
    function automatic logic [1:0] flush_bytes(input logic [1:0] n);
        logic [1:0] k;
        k = 2'd0;
        unique case (n)
            CNT_TWO:   k = 2'd1;
            CNT_THREE: k = 2'd2;
            default:   k = 2'd0;
        endcase
        return k;
    endfunction

endpackage

// File: design/b64d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decoder front end
// Classifies each character, gathers sextets and turns every transaction
// that yields output into one job for the queue.
// ----------------------------------------------------------------------------
module b64d_front
    import b64d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,      // input transaction taken this cycle
    input  logic [7:0] char_code,
    input  logic       eom,
    output logic       job_push,
    output job_t       job
);

    logic [17:0] group_reg, group_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        stopped_reg, stopped_next;

    logic [6:0]  v;
    logic [23:0] word;
    logic [1:0]  k;

    assign v = sextet_of(char_code);

    // Character handling, then end-of-message flush
    always_comb begin
        group_next   = group_reg;
        cnt_next     = cnt_reg;
        stopped_next = stopped_reg;
        word         = '0;
        k            = 2'd0;
        if (!stopped_reg) begin
            if (v != SEXTET_NONE) begin
                if (cnt_reg == CNT_THREE) begin
                    word       = {group_reg, v[5:0]};
                    k          = 2'd3;
                    group_next = '0;
                    cnt_next   = CNT_ZERO;
                end else begin
                    group_next = {group_reg[11:0], v[5:0]};
                    cnt_next   = cnt_reg + 2'd1;
                end
            end else begin
                word         = align_partial(group_reg, cnt_reg);
                k            = flush_bytes(cnt_reg);
                group_next   = '0;
                cnt_next     = CNT_ZERO;
                stopped_next = 1'b1;
            end
        end
        if (eom) begin
            // any earlier flush already emptied the group
            if (k == 2'd0) begin
                word = align_partial(group_next, cnt_next);
                k    = flush_bytes(cnt_next);
            end
            group_next   = '0;
            cnt_next     = CNT_ZERO;
            stopped_next = 1'b0;
        end
    end

    // Job build
    always_comb begin
        job.word   = word;
        job.bvalid = (k != 2'd0);
        job.nres   = (k == 2'd0) ? 2'd1 : k;
        job.done   = eom;
    end

    assign job_push = accept && ((k != 2'd0) || eom);

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_reg   <= '0;
            cnt_reg     <= CNT_ZERO;
            stopped_reg <= 1'b0;
        end else if (accept) begin
            group_reg   <= group_next;
            cnt_reg     <= cnt_next;
            stopped_reg <= stopped_next;
        end
    end

    // End of message returns the decoder to its reset state
    a_eom_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && eom |=> cnt_reg == CNT_ZERO && !stopped_reg && group_reg == '0)
        else $error("state not cleared after end of message");

    // A data-less job only ever closes a message
    a_empty_job_done: assert property (@(posedge aclk) disable iff (!aresetn)
        job_push && !job.bvalid |-> job.done)
        else $error("data-less job outside end of message");

endmodule

// File: design/b64d_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decoder job queue
// Small register FIFO between front end and back end.
// ----------------------------------------------------------------------------
module b64d_queue
    import b64d_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic empty,
    output job_t head
);

    job_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg, count_next;

    assign full  = (count_reg == (QAW+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full job queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty job queue");

endmodule

// File: design/b64d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decoder back end
// Splits each job into output register results, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module b64d_back
    import b64d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    input  job_t        q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       bvalid_reg, done_reg, lastitem_reg;
    logic [1:0] idx_reg;

    logic       load;
    logic       last_res;
    logic [7:0] sel_byte;

    // Output register takes a new result when empty or being drained
    assign load     = !q_empty && (!valid_reg || m_tready);
    assign last_res = (idx_reg == q_head.nres - 2'd1);
    assign q_pop    = load && last_res;

    always_comb begin
        case (idx_reg)
            2'd0:    sel_byte = q_head.word[23:16];
            2'd1:    sel_byte = q_head.word[15:8];
            default: sel_byte = q_head.word[7:0];
        endcase
    end

    // Result index within the current job
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
        end else if (load) begin
            idx_reg <= last_res ? 2'd0 : idx_reg + 2'd1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg     <= sel_byte;
            bvalid_reg   <= q_head.bvalid;
            lastitem_reg <= last_res;
            done_reg     <= q_head.done && last_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'b0, lastitem_reg, byte_reg};
    assign m_tuser  = bvalid_reg;
    assign m_tlast  = done_reg;

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && done_reg |-> lastitem_reg)
        else $error("message end not on last result of item");

    a_nodata_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !bvalid_reg |-> done_reg && byte_reg == 8'd0)
        else $error("data-less result that does not end the message");

endmodule

// File: design/base64_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decoder top level
// One character per input transaction, decoded bytes out one per transaction.
// ----------------------------------------------------------------------------
// The block takes one character per cycle while s_tready is high (s_tlast
// marks the last one of a message) and returns 0 to 3 result transactions
// per character, one per cycle while m_tready keeps up. A character is
// decoded in the cycle it is accepted; its bytes go into a four-entry job
// queue and the back end shifts them out through the output register.
// Sustained input rate is one character per cycle for ordinary Base64 text;
// s_tready drops only when the job queue is full. On the output, m_tdata[7:0]
// is the byte, m_tdata[8] marks the last result of a character, m_tuser says
// the byte is valid and m_tlast marks the end of the message. '=' or any
// character outside the alphabet ends decoding until the message end.
module base64_decoder_top
    import b64d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [8] last_of_item, rest zero
    output logic        m_tuser,   // [0] byte_valid
    output logic        m_tlast    // message_done
);

    logic accept;
    logic job_push;
    job_t job;
    logic q_full, q_empty, q_pop;
    job_t q_head;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    b64d_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .char_code (s_tdata),
        .eom       (s_tlast),
        .job_push  (job_push),
        .job       (job)
    );

    b64d_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (job),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    b64d_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decoder testbench
// Streams messages of characters into base64_decoder_top and checks every
// decoded byte, the data-less end results and the per-character and
// end-of-message marks against a behavioral decoder kept in step with the
// input transactions. Directed messages cover the padding, stop and
// end-of-message cases; random messages are mostly well-formed Base64 with
// random content, plus noise and broken messages. Both sides stall at random,
// and the receiver holds off once for a long stretch to fill the job queue.
// ----------------------------------------------------------------------------
module tb_top
    import b64d_pkg::*;
();

    localparam logic [7:0] CHAR_PAD     = 8'h3d;  // '='
    localparam int         CHAR_TARGET  = 430;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         HOLD_CYCLES  = 80;
    localparam int         MAX_REPORTS  = 10;

    // One input character and one decoded result
    typedef struct packed {
        logic [7:0] code;
        logic       eom;
    } char_item_t;

    typedef struct packed {
        logic [7:0] dbyte;
        logic       bvalid;
        logic       done;
        logic       last;
    } dec_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // [7:0] data_byte, [8] last_of_item, rest zero
    logic        m_tuser;   // [0] byte_valid
    logic        m_tlast;

    char_item_t  char_q[$];      // characters waiting to be driven
    dec_result_t decoded_q[$];   // results the decoder must still return

    // Decoder state mirrored from the accepted characters
    logic [17:0] grp_bits  = '0;
    logic [1:0]  grp_count = CNT_ZERO;
    logic        halted    = 1'b0;

    int  chars_in    = 0;
    int  mismatches  = 0;
    int  stall_count = 0;
    int  hold_left   = 0;
    bit  hold_done   = 1'b0;
    bit  in_taken    = 1'b0;

    base64_decoder_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    // Alphabet index to character
    function automatic logic [7:0] b64_char(input int idx);
        if (idx < 26) begin
            return 8'(8'h41 + idx);
        end else if (idx < 52) begin
            return 8'(8'h61 + idx - 26);
        end else if (idx < 62) begin
            return 8'(8'h30 + idx - 52);
        end else if (idx == 62) begin
            return CHAR_PLUS;
        end
        return CHAR_SLASH;
    endfunction

    // Character to sextet, SEXTET_NONE outside the alphabet
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return 7'(c - "A");
        end else if (c >= "a" && c <= "z") begin
            return 7'(c - "a" + 26);
        end else if (c >= "0" && c <= "9") begin
            return 7'(c - "0" + 52);
        end else if (c == CHAR_PLUS) begin
            return 7'd62;
        end else if (c == CHAR_SLASH) begin
            return 7'd63;
        end
        return SEXTET_NONE;
    endfunction

    task automatic add_char(input logic [7:0] c, input logic eom);
        char_item_t it;
        it.code = c;
        it.eom  = eom;
        char_q.push_back(it);
    endtask

    // Bytes of a partial group, then clear it
    task automatic flush_group(ref dec_result_t res[$]);
        if (grp_count == CNT_TWO) begin
            res.push_back('{{grp_bits[11:6], grp_bits[5:4]}, 1'b1, 1'b0, 1'b0});
        end else if (grp_count == CNT_THREE) begin
            res.push_back('{{grp_bits[17:12], grp_bits[11:10]}, 1'b1, 1'b0, 1'b0});
            res.push_back('{{grp_bits[9:6], grp_bits[5:2]}, 1'b1, 1'b0, 1'b0});
        end
        grp_bits  = '0;
        grp_count = CNT_ZERO;
    endtask

    // Expected results of one accepted character
    task automatic decode_char(input char_item_t it);
        dec_result_t res[$];
        logic [6:0]  v;
        if (!halted) begin
            v = char_sextet(it.code);
            if (v != SEXTET_NONE) begin
                if (grp_count == CNT_THREE) begin
                    res.push_back('{{grp_bits[17:12], grp_bits[11:10]}, 1'b1, 1'b0, 1'b0});
                    res.push_back('{{grp_bits[9:6], grp_bits[5:2]}, 1'b1, 1'b0, 1'b0});
                    res.push_back('{{grp_bits[1:0], v[5:0]}, 1'b1, 1'b0, 1'b0});
                    grp_bits  = '0;
                    grp_count = CNT_ZERO;
                end else begin
                    grp_bits  = {grp_bits[11:0], v[5:0]};
                    grp_count = grp_count + 2'd1;
                end
            end else begin
                flush_group(res);
                halted = 1'b1;
            end
        end
        if (it.eom) begin
            flush_group(res);
            if (res.size() == 0) begin
                res.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
            end
            res[res.size()-1].done = 1'b1;
            halted = 1'b0;
        end
        if (res.size() > 0) begin
            res[res.size()-1].last = 1'b1;
        end
        foreach (res[i]) begin
            decoded_q.push_back(res[i]);
        end
    endtask

    // Random message: mostly well-formed text, some noise and broken text
    task automatic add_random_message();
        int kind;
        int len;
        int rem;
        int npad;
        int cut;
        logic [7:0] msg[$];
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            len = 4 * $urandom_range(0, 5);
            rem = $urandom_range(0, 3);
            len += rem;
            for (int i = 0; i < len; i++) begin
                msg.push_back(b64_char($urandom_range(0, 63)));
            end
            if (rem > 0 && $urandom_range(0, 1) == 1) begin
                npad = 4 - rem;
                for (int i = 0; i < npad; i++) begin
                    msg.push_back(CHAR_PAD);
                end
            end
        end else if (kind == 7) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                msg.push_back(8'($urandom_range(0, 255)));
            end
        end else begin
            len = $urandom_range(2, 12);
            cut = $urandom_range(0, len - 1);
            for (int i = 0; i < len; i++) begin
                if (i == cut) begin
                    msg.push_back(8'($urandom_range(0, 255)));
                end else begin
                    msg.push_back(b64_char($urandom_range(0, 63)));
                end
            end
        end
        if (msg.size() == 0) begin
            msg.push_back($urandom_range(0, 1) ? CHAR_PAD : b64_char($urandom_range(0, 63)));
        end
        foreach (msg[i]) begin
            add_char(msg[i], i == msg.size() - 1);
        end
    endtask

    // Input side: accept, predict; output side: compare with the oldest expectation
    always @(posedge aclk) begin
        dec_result_t want;
        in_taken = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                decode_char('{s_tdata, s_tlast});
                chars_in++;
                in_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("[%0t] unexpected result: tdata=%h tuser=%b tlast=%b",
                                 $realtime, m_tdata, m_tuser, m_tlast);
                    end
                end else begin
                    want = decoded_q.pop_front();
                    if (m_tdata[7:0] !== want.dbyte || m_tdata[8] !== want.last ||
                        m_tdata[15:9] !== 7'd0 || m_tuser !== want.bvalid ||
                        m_tlast !== want.done) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            // expected byte/valid/done/last, got tdata/tuser/tlast
                            $display("[%0t] mismatch: exp %h/%b/%b/%b got %h/%b/%b",
                                     $realtime, want.dbyte, want.bvalid, want.done,
                                     want.last, m_tdata, m_tuser, m_tlast);
                        end
                    end
                end
            end
            // Watchdog on cycles without any transaction
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_count = 0;
            end else begin
                stall_count++;
                if (stall_count >= STALL_LIMIT) begin
                    $display("tb_top failed");
                    $finish;
                end
            end
        end
    end

    // Character driver, with random gaps outside the quiet window
    always @(negedge aclk) begin
        char_item_t it;
        bit calm;
        calm = (chars_in >= 150 && chars_in < 250);
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (char_q.size() > 0 && (calm || $urandom_range(0, 99) >= 7)) begin
                it = char_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= it.code;
                s_tlast  <= it.eom;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls and one long hold-off
    always @(negedge aclk) begin
        bit calm;
        calm = (chars_in >= 150 && chars_in < 250);
        if (!hold_done && chars_in >= 300) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 7);
        end
    end

    initial begin
        // Directed messages
        add_char("T", 1'b0); add_char("W", 1'b0); add_char("F", 1'b0); add_char("u", 1'b0);
        add_char("T", 1'b0); add_char("Q", 1'b0); add_char(CHAR_PAD, 1'b0);
        add_char(CHAR_PAD, 1'b1);                 // ignored after the stop, end only
        add_char("A", 1'b1);                      // lone sextet gives no byte
        add_char(8'h00, 1'b1);                    // foreign character on an empty group
        add_char(CHAR_PLUS, 1'b0); add_char(CHAR_SLASH, 1'b0);
        add_char("9", 1'b0); add_char("z", 1'b1); // group completes on the last char
        add_char("a", 1'b0); add_char("z", 1'b0);
        add_char("0", 1'b1);                      // three sextets flushed at the end
        add_char("Z", 1'b0); add_char(8'hff, 1'b0);
        add_char("Y", 1'b0); add_char("A", 1'b1); // characters after a stop
        add_char("P", 1'b0); add_char("w", 1'b1); // two sextets flushed at the end
        while (char_q.size() < CHAR_TARGET) begin
            add_random_message();
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Wait for the stimulus to drain and every result to come back
        while (char_q.size() > 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (decoded_q.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// File: base64_decoder_top.f
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64_decoder_top.sv
tb/tb_top.sv
